@@ hw/rtl/cpcb_pkg.sv @@
// cpcb_pkg: shared widths, codes, stage payload types and color conversion
// functions for the clipped pixel convert blit
// no dependencies
package cpcb_pkg;

   localparam int MAX_DIM  = 2048;
   localparam int DIM_W    = 12;
   localparam int COORD_W  = 12;
   localparam int POS_W    = COORD_W + 2;
   localparam int IDX_W    = $clog2(MAX_DIM);
   localparam int STRIDE_W = 14;
   localparam int PIX_W    = 24;
   localparam int WORD_W   = 16;
   localparam int ADDR_W   = 22;
   localparam int PROD_W   = IDX_W + DIM_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_READY   = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ST_INVALID     = 2'd3;

   localparam logic [1:0] FMT_RGB565 = 2'd0;
   localparam logic [1:0] FMT_RGB444 = 2'd1;
   localparam logic [1:0] FMT_RGB888 = 2'd2;
   localparam logic [1:0] FMT_NONE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_BYTES    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_READY = 2'd3;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(800);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
   localparam logic [DIM_W-1:0] MAX_DIM_VAL      = DIM_W'(MAX_DIM);
   localparam logic [DIM_W:0]   MAX_DIM_WIDE     = (DIM_W+1)'(MAX_DIM);

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic             swap_bytes;
      logic             display_ready;
   } cfg_type;

   typedef struct packed {
      logic              not_ready;
      logic              fmt_bad;
      logic              stride_bad;
      pos_type           x1;
      pos_type           x2;
      pos_type           y1;
      pos_type           y2;
      pos_type           dx;
      pos_type           dy;
      logic [WORD_W-1:0] word;
   } s1_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              write_enable;
      logic [IDX_W-1:0]  dx;
      logic [IDX_W-1:0]  dy;
      logic [WORD_W-1:0] word;
   } s2_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              write_enable;
      logic [ADDR_W-1:0] pixel_address;
      logic [WORD_W-1:0] pixel_data;
   } rsp_type;

   function automatic logic [WORD_W-1:0] conv_444(input logic [PIX_W-1:0] p);
      return {p[11:8], p[11], p[7:4], p[7:6], p[3:0], p[3]};
   endfunction

   function automatic logic [WORD_W-1:0] conv_888(input logic [PIX_W-1:0] p);
      return {p[23:19], p[15:10], p[7:3]};
   endfunction

   function automatic logic [WORD_W-1:0] swap16(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8]};
   endfunction

endpackage

@@ hw/rtl/cpcb_ifs.sv @@
// cpcb_ifs: valid/ready channel interfaces for requests and responses
// depends on cpcb_pkg
interface cpcb_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cpcb_pkg::COORD_W-1:0]   rect_x;
   logic signed [cpcb_pkg::COORD_W-1:0]   rect_y;
   logic [cpcb_pkg::COORD_W-1:0]          rect_width;
   logic [cpcb_pkg::COORD_W-1:0]          rect_height;
   logic [cpcb_pkg::STRIDE_W-1:0]         row_stride;
   logic [1:0]                            pixel_format;
   logic [cpcb_pkg::COORD_W-1:0]          source_column;
   logic [cpcb_pkg::COORD_W-1:0]          source_row;
   logic [cpcb_pkg::PIX_W-1:0]            pixel_value;

   modport source (
      output valid, rect_x, rect_y, rect_width, rect_height, row_stride,
             pixel_format, source_column, source_row, pixel_value,
      input  ready
   );
   modport sink (
      input  valid, rect_x, rect_y, rect_width, rect_height, row_stride,
             pixel_format, source_column, source_row, pixel_value,
      output ready
   );
endinterface

interface cpcb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic                          write_enable;
   logic [cpcb_pkg::ADDR_W-1:0]   pixel_address;
   logic [cpcb_pkg::WORD_W-1:0]   pixel_data;

   modport source (
      output valid, status, write_enable, pixel_address, pixel_data,
      input  ready
   );
   modport sink (
      input  valid, status, write_enable, pixel_address, pixel_data,
      output ready
   );
endinterface

@@ hw/rtl/cpcb_csr.sv @@
// cpcb_csr: frame size, swap and display ready registers with frame size saturation
// depends on cpcb_pkg
module cpcb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [cpcb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpcb_pkg::CSR_DATA_W-1:0]    csr_data,
   output cpcb_pkg::cfg_type                  cfg
);

   logic [cpcb_pkg::DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [cpcb_pkg::DIM_W-1:0] frame_height_ff, frame_height_in;
   logic                       swap_bytes_ff, swap_bytes_in;
   logic                       display_ready_ff, display_ready_in;

   always_comb begin
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      swap_bytes_in    = swap_bytes_ff;
      display_ready_in = display_ready_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cpcb_pkg::CSR_FRAME_WIDTH:   frame_width_in   = csr_data[cpcb_pkg::DIM_W-1:0];
            cpcb_pkg::CSR_FRAME_HEIGHT:  frame_height_in  = csr_data[cpcb_pkg::DIM_W-1:0];
            cpcb_pkg::CSR_SWAP_BYTES:    swap_bytes_in    = csr_data[0];
            cpcb_pkg::CSR_DISPLAY_READY: display_ready_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= cpcb_pkg::FRAME_WIDTH_RST;
         frame_height_ff  <= cpcb_pkg::FRAME_HEIGHT_RST;
         swap_bytes_ff    <= 1'b0;
         display_ready_ff <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         swap_bytes_ff    <= swap_bytes_in;
         display_ready_ff <= display_ready_in;
      end
   end

   always_comb begin
      cfg.frame_width   = ({1'b0, frame_width_ff} > cpcb_pkg::MAX_DIM_WIDE) ?
                          cpcb_pkg::MAX_DIM_VAL : frame_width_ff;
      cfg.frame_height  = ({1'b0, frame_height_ff} > cpcb_pkg::MAX_DIM_WIDE) ?
                          cpcb_pkg::MAX_DIM_VAL : frame_height_ff;
      cfg.swap_bytes    = swap_bytes_ff;
      cfg.display_ready = display_ready_ff;
   end

endmodule

@@ hw/rtl/cpcb_front.sv @@
// cpcb_front: first stage, clip bounds, destination position, stride check and
// color conversion to rgb565; depends on cpcb_pkg and cpcb_ifs
module cpcb_front (
   input  logic               clock,
   input  logic               reset,
   input  cpcb_pkg::cfg_type  cfg,
   cpcb_req_if.sink           req_if,
   input  logic               down_ready,
   output logic               s1_valid,
   output cpcb_pkg::s1_type   s1
);

   logic               valid_ff, valid_in;
   cpcb_pkg::s1_type   s1_ff, s1_in;
   logic               stage_ready;

   cpcb_pkg::pos_type  rx, ry, rw, rh, col, row, fw, fh;
   cpcb_pkg::pos_type  x2_sum, y2_sum;
   logic [cpcb_pkg::STRIDE_W-1:0] rw2, need;
   logic [cpcb_pkg::WORD_W-1:0]   word;

   assign stage_ready  = !valid_ff || down_ready;
   assign req_if.ready = stage_ready;

   always_comb begin
      rx  = $signed({{2{req_if.rect_x[cpcb_pkg::COORD_W-1]}}, req_if.rect_x});
      ry  = $signed({{2{req_if.rect_y[cpcb_pkg::COORD_W-1]}}, req_if.rect_y});
      rw  = $signed({2'b00, req_if.rect_width});
      rh  = $signed({2'b00, req_if.rect_height});
      col = $signed({2'b00, req_if.source_column});
      row = $signed({2'b00, req_if.source_row});
      fw  = $signed({2'b00, cfg.frame_width});
      fh  = $signed({2'b00, cfg.frame_height});

      x2_sum = rx + rw;
      y2_sum = ry + rh;

      rw2  = {1'b0, req_if.rect_width, 1'b0};
      need = (req_if.pixel_format == cpcb_pkg::FMT_RGB888) ?
             rw2 + {2'b00, req_if.rect_width} : rw2;

      case (req_if.pixel_format)
         cpcb_pkg::FMT_RGB565: word = req_if.pixel_value[cpcb_pkg::WORD_W-1:0];
         cpcb_pkg::FMT_RGB444: word = cpcb_pkg::conv_444(req_if.pixel_value);
         cpcb_pkg::FMT_RGB888: word = cpcb_pkg::conv_888(req_if.pixel_value);
         default:              word = '0;
      endcase

      s1_in.not_ready  = !cfg.display_ready;
      s1_in.fmt_bad    = (req_if.pixel_format == cpcb_pkg::FMT_NONE);
      s1_in.stride_bad = (req_if.row_stride < need);
      s1_in.x1         = rx[cpcb_pkg::POS_W-1] ? '0 : rx;
      s1_in.y1         = ry[cpcb_pkg::POS_W-1] ? '0 : ry;
      s1_in.x2         = (x2_sum > fw) ? fw : x2_sum;
      s1_in.y2         = (y2_sum > fh) ? fh : y2_sum;
      s1_in.dx         = rx + col;
      s1_in.dy         = ry + row;
      s1_in.word       = cfg.swap_bytes ? cpcb_pkg::swap16(word) : word;

      valid_in = stage_ready ? req_if.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && req_if.valid) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1       = s1_ff;

endmodule

@@ hw/rtl/cpcb_check.sv @@
// cpcb_check: second stage, status priority, clip test and zeroing of
// rejected results; depends on cpcb_pkg
module cpcb_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  cpcb_pkg::s1_type   s1,
   input  logic               down_ready,
   output logic               s2_valid,
   output cpcb_pkg::s2_type   s2
);

   logic               valid_ff, valid_in;
   cpcb_pkg::s2_type   s2_ff, s2_in;
   logic               empty, in_clip;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      empty   = (s1.x1 >= s1.x2) || (s1.y1 >= s1.y2);
      in_clip = (s1.dx >= s1.x1) && (s1.dx < s1.x2) &&
                (s1.dy >= s1.y1) && (s1.dy < s1.y2);

      s2_in.write_enable = 1'b0;
      if (s1.not_ready) begin
         s2_in.status = cpcb_pkg::ST_NOT_READY;
      end else if (s1.fmt_bad) begin
         s2_in.status = cpcb_pkg::ST_UNSUPPORTED;
      end else if (s1.stride_bad || empty) begin
         s2_in.status = cpcb_pkg::ST_INVALID;
      end else begin
         s2_in.status       = cpcb_pkg::ST_OK;
         s2_in.write_enable = in_clip;
      end

      s2_in.dx   = s2_in.write_enable ? s1.dx[cpcb_pkg::IDX_W-1:0] : '0;
      s2_in.dy   = s2_in.write_enable ? s1.dy[cpcb_pkg::IDX_W-1:0] : '0;
      s2_in.word = s2_in.write_enable ? s1.word : '0;

      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = valid_ff;
   assign s2       = s2_ff;

endmodule

@@ hw/rtl/cpcb_addr.sv @@
// cpcb_addr: third stage row times frame width product, then output register
// adding the column; depends on cpcb_pkg
module cpcb_addr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [cpcb_pkg::DIM_W-1:0]  frame_width,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  cpcb_pkg::s2_type            s2,
   input  logic                        out_ready,
   output logic                        out_valid,
   output cpcb_pkg::rsp_type           out
);

   logic                          s3_valid_ff, s3_valid_in;
   logic [cpcb_pkg::PROD_W-1:0]   prod_ff, prod_in;
   cpcb_pkg::s2_type              s3_ff;
   logic                          s3_ready;

   logic                          out_valid_ff, out_valid_in;
   cpcb_pkg::rsp_type             out_ff, out_in;
   logic                          out_stage_ready;

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign s3_ready        = !s3_valid_ff || out_stage_ready;
   assign up_ready        = s3_ready;

   always_comb begin
      prod_in     = s2.dy * frame_width;
      s3_valid_in = s3_ready ? up_valid : s3_valid_ff;

      out_in.status        = s3_ff.status;
      out_in.write_enable  = s3_ff.write_enable;
      out_in.pixel_address = cpcb_pkg::ADDR_W'(prod_ff) +
                             cpcb_pkg::ADDR_W'(s3_ff.dx);
      out_in.pixel_data    = s3_ff.word;
      out_valid_in = out_stage_ready ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && up_valid) begin
         prod_ff <= prod_in;
         s3_ff   <= s2;
      end
      if (out_stage_ready && s3_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out       = out_ff;

`ifndef ASSERT_OFF
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.write_enable |->
         out_ff.pixel_address == '0 && out_ff.pixel_data == '0)
      else $error("rejected pixel carries nonzero address or data");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.write_enable |-> out_ff.status == cpcb_pkg::ST_OK)
      else $error("write enable with error status");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_stage_ready |=> s3_valid_ff && $stable(prod_ff) &&
         $stable(s3_ff))
      else $error("product stage changed while stalled");

   a_s3_drain: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && out_stage_ready |=> out_valid_ff)
      else $error("product stage transfer lost");
`endif

endmodule

@@ hw/rtl/clipped_pixel_convert_blit.sv @@
// clipped_pixel_convert_blit: top level of the clipped rgb565 convert blit
// one pixel per cycle while the response side is ready
// four register stages: bounds/convert, check, multiply, output
// a stalled response holds every occupied stage in place, nothing is dropped or repeated
// synchronous reset empties the pipeline and restores 800x480, no swap, display not ready
// depends on cpcb_pkg, cpcb_ifs, cpcb_csr, cpcb_front, cpcb_check, cpcb_addr
module clipped_pixel_convert_blit (
   input  logic                               clock,
   input  logic                               reset,
   cpcb_req_if.sink                           req_if,
   cpcb_rsp_if.source                         rsp_if,
   input  logic                               csr_write_enable,
   input  logic [cpcb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpcb_pkg::CSR_DATA_W-1:0]    csr_data
);

   cpcb_pkg::cfg_type  cfg;
   cpcb_pkg::s1_type   s1;
   cpcb_pkg::s2_type   s2;
   cpcb_pkg::rsp_type  rsp;
   logic               s1_valid, s1_ready;
   logic               s2_valid, s2_ready;

   cpcb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   cpcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_if     (req_if),
      .down_ready (s1_ready),
      .s1_valid   (s1_valid),
      .s1         (s1)
   );

   cpcb_check u_check (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (s1_valid),
      .up_ready   (s1_ready),
      .s1         (s1),
      .down_ready (s2_ready),
      .s2_valid   (s2_valid),
      .s2         (s2)
   );

   cpcb_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .frame_width (cfg.frame_width),
      .up_valid    (s2_valid),
      .up_ready    (s2_ready),
      .s2          (s2),
      .out_ready   (rsp_if.ready),
      .out_valid   (rsp_if.valid),
      .out         (rsp)
   );

   assign rsp_if.status        = rsp.status;
   assign rsp_if.write_enable  = rsp.write_enable;
   assign rsp_if.pixel_address = rsp.pixel_address;
   assign rsp_if.pixel_data    = rsp.pixel_data;

endmodule

@@ tb/sv/clipped_pixel_convert_blit_tb.sv @@
// clipped_pixel_convert_blit_tb: self-checking bench for the clipped rgb565 blit, with its own
// pixel predictor, directed status/format/clip cases, random traffic and back-pressure runs
// depends on cpcb_pkg, cpcb_ifs and clipped_pixel_convert_blit
module clipped_pixel_convert_blit_tb;
   import cpcb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 178;

   typedef struct packed {
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic [COORD_W-1:0]        rect_width;
      logic [COORD_W-1:0]        rect_height;
      logic [STRIDE_W-1:0]       row_stride;
      logic [1:0]                pixel_format;
      logic [COORD_W-1:0]        source_column;
      logic [COORD_W-1:0]        source_row;
      logic [PIX_W-1:0]          pixel_value;
   } pixel_req_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cpcb_req_if req_ch();
   cpcb_rsp_if rsp_ch();

   clipped_pixel_convert_blit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // register shadow used for prediction
   logic [DIM_W-1:0] frame_w_reg = FRAME_WIDTH_RST;
   logic [DIM_W-1:0] frame_h_reg = FRAME_HEIGHT_RST;
   logic             swap_reg    = 1'b0;
   logic             ready_reg   = 1'b0;

   rsp_type    expected_writes[$];
   pixel_req_t directed_items[$];
   int fail_count    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pixel_req_t make_req(input int rx, input int ry, input int rw,
                                           input int rh, input int stride,
                                           input logic [1:0] fmt, input int col,
                                           input int row, input logic [PIX_W-1:0] pix);
      pixel_req_t q;
      q.rect_x        = COORD_W'(rx);
      q.rect_y        = COORD_W'(ry);
      q.rect_width    = COORD_W'(rw);
      q.rect_height   = COORD_W'(rh);
      q.row_stride    = STRIDE_W'(stride);
      q.pixel_format  = fmt;
      q.source_column = COORD_W'(col);
      q.source_row    = COORD_W'(row);
      q.pixel_value   = pix;
      return q;
   endfunction

   function automatic rsp_type blit_pixel(input pixel_req_t q);
      int rx, ry, rw, rh, stride, col, row, fw, fh, bpp, x1, x2, y1, y2, dx, dy;
      logic [WORD_W-1:0] word;
      rsp_type r;
      r = '0;
      rx = q.rect_x;
      ry = q.rect_y;
      rw = q.rect_width;
      rh = q.rect_height;
      stride = q.row_stride;
      col = q.source_column;
      row = q.source_row;
      fw = frame_w_reg;
      fh = frame_h_reg;
      if (fw > MAX_DIM) fw = MAX_DIM;
      if (fh > MAX_DIM) fh = MAX_DIM;
      if (!ready_reg) begin
         r.status = ST_NOT_READY;
      end else if (q.pixel_format == FMT_NONE) begin
         r.status = ST_UNSUPPORTED;
      end else begin
         bpp = (q.pixel_format == FMT_RGB888) ? 3 : 2;
         x1 = (rx < 0) ? 0 : rx;
         y1 = (ry < 0) ? 0 : ry;
         x2 = (rx + rw > fw) ? fw : rx + rw;
         y2 = (ry + rh > fh) ? fh : ry + rh;
         if (stride < rw * bpp || x1 >= x2 || y1 >= y2) begin
            r.status = ST_INVALID;
         end else begin
            r.status = ST_OK;
            dx = rx + col;
            dy = ry + row;
            if (dx >= x1 && dx < x2 && dy >= y1 && dy < y2) begin
               case (q.pixel_format)
                  FMT_RGB565: word = q.pixel_value[15:0];
                  FMT_RGB444: word = {q.pixel_value[11:8], q.pixel_value[11],
                                      q.pixel_value[7:4], q.pixel_value[7:6],
                                      q.pixel_value[3:0], q.pixel_value[3]};
                  default:    word = {q.pixel_value[23:19], q.pixel_value[15:10],
                                      q.pixel_value[7:3]};
               endcase
               if (swap_reg) word = {word[7:0], word[15:8]};
               r.write_enable  = 1'b1;
               r.pixel_address = ADDR_W'(dy * fw + dx);
               r.pixel_data    = word;
            end
         end
      end
      return r;
   endfunction

   // mostly requests that overlap the frame, the rest raw noise
   function automatic pixel_req_t random_pixel();
      pixel_req_t q;
      int fw, fh, rw, rh, bpp, rx, ry, x1, x2, y1, y2, col, row, stride, pick;
      logic [1:0] fmt;
      if ($urandom_range(0, 9) < 3) begin
         q.rect_x        = COORD_W'($urandom);
         q.rect_y        = COORD_W'($urandom);
         q.rect_width    = COORD_W'($urandom);
         q.rect_height   = COORD_W'($urandom);
         q.row_stride    = STRIDE_W'($urandom);
         q.pixel_format  = 2'($urandom);
         q.source_column = COORD_W'($urandom);
         q.source_row    = COORD_W'($urandom);
         q.pixel_value   = PIX_W'($urandom);
         return q;
      end
      fw = frame_w_reg;
      fh = frame_h_reg;
      if (fw > MAX_DIM) fw = MAX_DIM;
      if (fh > MAX_DIM) fh = MAX_DIM;
      if (fw == 0) fw = 1;
      if (fh == 0) fh = 1;
      fmt = ($urandom_range(0, 32) == 0) ? FMT_NONE : 2'($urandom_range(0, 2));
      bpp = (fmt == FMT_RGB888) ? 3 : 2;
      rw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 64);
      rh = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 64);
      rx = int'($urandom_range(0, fw + rw - 1)) - rw + 1;
      ry = int'($urandom_range(0, fh + rh - 1)) - rh + 1;
      if (rx < -2048) rx = -2048;
      if (ry < -2048) ry = -2048;
      x1 = (rx < 0) ? 0 : rx;
      y1 = (ry < 0) ? 0 : ry;
      x2 = (rx + rw > fw) ? fw : rx + rw;
      y2 = (ry + rh > fh) ? fh : ry + rh;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         col = int'($urandom_range(x1, x2 - 1)) - rx;
         row = int'($urandom_range(y1, y2 - 1)) - ry;
      end else if (pick < 85) begin
         col = $urandom_range(0, rw - 1);
         row = $urandom_range(0, rh - 1);
      end else begin
         col = $urandom_range(0, 4095);
         row = $urandom_range(0, 4095);
      end
      stride = rw * bpp;
      if ($urandom_range(0, 9) == 0) stride = stride - 1;
      else stride = stride + $urandom_range(0, 7);
      return make_req(rx, ry, rw, rh, stride, fmt, col, row, PIX_W'($urandom));
   endfunction

   // response check, then request prediction, then register shadow
   always @(posedge clock) begin : scoreboard
      rsp_type    actual;
      rsp_type    wanted;
      pixel_req_t seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            actual.status        = rsp_ch.status;
            actual.write_enable  = rsp_ch.write_enable;
            actual.pixel_address = rsp_ch.pixel_address;
            actual.pixel_data    = rsp_ch.pixel_data;
            if (expected_writes.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response transfer: st=%0d we=%0d addr=%0h data=%0h",
                           actual.status, actual.write_enable, actual.pixel_address,
                           actual.pixel_data);
               fail_count++;
            end else begin
               wanted = expected_writes.pop_front();
               if (actual.status !== wanted.status ||
                   actual.write_enable !== wanted.write_enable ||
                   actual.pixel_address !== wanted.pixel_address ||
                   actual.pixel_data !== wanted.pixel_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d/%0d/%0h/%0h actual %0d/%0d/%0h/%0h",
                              wanted.status, wanted.write_enable, wanted.pixel_address,
                              wanted.pixel_data, actual.status, actual.write_enable,
                              actual.pixel_address, actual.pixel_data);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.rect_x        = req_ch.rect_x;
            seen.rect_y        = req_ch.rect_y;
            seen.rect_width    = req_ch.rect_width;
            seen.rect_height   = req_ch.rect_height;
            seen.row_stride    = req_ch.row_stride;
            seen.pixel_format  = req_ch.pixel_format;
            seen.source_column = req_ch.source_column;
            seen.source_row    = req_ch.source_row;
            seen.pixel_value   = req_ch.pixel_value;
            expected_writes.push_back(blit_pixel(seen));
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_WIDTH:   frame_w_reg = csr_data;
               CSR_FRAME_HEIGHT:  frame_h_reg = csr_data;
               CSR_SWAP_BYTES:    swap_reg    = csr_data[0];
               CSR_DISPLAY_READY: ready_reg   = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_pixel(input pixel_req_t q, input bit last);
      req_ch.valid         <= 1'b1;
      req_ch.rect_x        <= q.rect_x;
      req_ch.rect_y        <= q.rect_y;
      req_ch.rect_width    <= q.rect_width;
      req_ch.rect_height   <= q.rect_height;
      req_ch.row_stride    <= q.row_stride;
      req_ch.pixel_format  <= q.pixel_format;
      req_ch.source_column <= q.source_column;
      req_ch.source_row    <= q.source_row;
      req_ch.pixel_value   <= q.pixel_value;
      do @(posedge clock); while (!req_ch.ready);
      if (last || $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (!last && $urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   task automatic send_list();
      foreach (directed_items[i]) send_pixel(directed_items[i], i == directed_items.size() - 1);
      directed_items.delete();
   endtask

   task automatic wait_drained();
      while (expected_writes.size() != 0) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // reset leaves the display closed, this outranks every other check
   task automatic test_not_ready();
      directed_items.push_back(make_req(0, 0, 10, 10, 0, FMT_NONE, 0, 0, 24'h123456));
      directed_items.push_back(make_req(10, 20, 16, 16, 32, FMT_RGB565, 3, 4, 24'h00f81f));
      send_list();
   endtask

   task automatic test_status_order();
      set_reg(CSR_DISPLAY_READY, 1);
      directed_items.push_back(make_req(0, 0, 10, 10, 0, FMT_NONE, 0, 0, 24'hffffff));
      directed_items.push_back(make_req(0, 0, 10, 1, 29, FMT_RGB888, 9, 0, 24'hffffff));
      directed_items.push_back(make_req(0, 0, 10, 1, 30, FMT_RGB888, 9, 0, 24'hffffff));
      directed_items.push_back(make_req(0, 0, 10, 1, 19, FMT_RGB565, 1, 0, 24'habcdef));
      directed_items.push_back(make_req(0, 0, 10, 1, 20, FMT_RGB565, 1, 0, 24'habcdef));
      directed_items.push_back(make_req(800, 0, 5, 5, 10, FMT_RGB565, 0, 0, 24'h000001));
      directed_items.push_back(make_req(0, 0, 0, 5, 0, FMT_RGB444, 0, 0, 24'h000fff));
      directed_items.push_back(make_req(0, 0, 10, 0, 20, FMT_RGB444, 0, 0, 24'h000fff));
      directed_items.push_back(make_req(2047, 2047, 1, 1, 2, FMT_RGB565, 0, 0, 24'hffff));
      send_list();
   endtask

   task automatic test_conversion_and_clip();
      directed_items.push_back(make_req(0, 0, 4, 4, 8, FMT_RGB444, 1, 1, 24'h000fff));
      directed_items.push_back(make_req(0, 0, 4, 4, 8, FMT_RGB444, 2, 3, 24'hfff842));
      directed_items.push_back(make_req(790, 470, 10, 10, 30, FMT_RGB888, 9, 9, 24'h000000));
      directed_items.push_back(make_req(790, 470, 10, 10, 30, FMT_RGB888, 8, 9, 24'h123456));
      directed_items.push_back(make_req(-2048, -2048, 4095, 4095, 16383, FMT_RGB565,
                                        0, 0, 24'h00ffff));
      directed_items.push_back(make_req(-2048, -2048, 4095, 4095, 16383, FMT_RGB565,
                                        2048, 2048, 24'h005a5a));
      directed_items.push_back(make_req(-2048, -2048, 4095, 4095, 16383, FMT_RGB565,
                                        4095, 4095, 24'hffffff));
      directed_items.push_back(make_req(-5, 0, 10, 1, 20, FMT_RGB565, 5, 0, 24'h00f00f));
      send_list();
      set_reg(CSR_SWAP_BYTES, 1);
      directed_items.push_back(make_req(3, 4, 2, 2, 4, FMT_RGB565, 1, 1, 24'h0012ab));
      send_list();
   endtask

   // oversized registers saturate, zero sizes leave nothing to draw
   task automatic test_frame_limits();
      set_reg(CSR_FRAME_WIDTH, 4095);
      set_reg(CSR_FRAME_HEIGHT, 4095);
      directed_items.push_back(make_req(2047, 2047, 1, 1, 3, FMT_RGB888, 0, 0, 24'h123456));
      directed_items.push_back(make_req(2040, 0, 100, 1, 200, FMT_RGB565, 8, 0, 24'h001234));
      send_list();
      set_reg(CSR_FRAME_WIDTH, 0);
      directed_items.push_back(make_req(0, 0, 4, 4, 8, FMT_RGB565, 0, 0, 24'h001234));
      send_list();
      set_reg(CSR_FRAME_WIDTH, 1);
      set_reg(CSR_FRAME_HEIGHT, 1);
      set_reg(CSR_SWAP_BYTES, 0);
      directed_items.push_back(make_req(0, 0, 1, 1, 2, FMT_RGB565, 0, 0, 24'h00beef));
      directed_items.push_back(make_req(-1, 0, 2, 1, 4, FMT_RGB565, 1, 0, 24'h00cafe));
      directed_items.push_back(make_req(-1, 0, 2, 1, 4, FMT_RGB565, 0, 0, 24'h00cafe));
      send_list();
      set_reg(CSR_FRAME_HEIGHT, 0);
      directed_items.push_back(make_req(0, 0, 1, 1, 2, FMT_RGB565, 0, 0, 24'h00beef));
      send_list();
   endtask

   task automatic test_random_traffic(input int mode);
      int k, fw, fh;
      case (mode)
         0: begin send_idle_pct = 37; recv_idle_pct = 58; end
         1: begin send_idle_pct = 58; recv_idle_pct = 37; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int j = 0; j < 3; j++) begin
         k = mode * 3 + j;
         case (k % 6)
            0: begin fw = 800; fh = 480; end
            1: begin fw = 1; fh = 1; end
            2: begin fw = 2048; fh = 2048; end
            3: begin fw = 4095; fh = 2500; end
            4: begin fw = 37; fh = 2047; end
            default: begin fw = $urandom_range(1, 2048); fh = $urandom_range(1, 2048); end
         endcase
         set_reg(CSR_FRAME_WIDTH, fw);
         set_reg(CSR_FRAME_HEIGHT, fh);
         set_reg(CSR_SWAP_BYTES, k % 2);
         set_reg(CSR_DISPLAY_READY, 1);
         for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_pixel(), i == PHASE_ITEMS - 1);
      end
   endtask

   // receiver stalls long enough for the pipeline to back up into the request side
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_reg(CSR_FRAME_WIDTH, 64);
      set_reg(CSR_FRAME_HEIGHT, 64);
      set_reg(CSR_SWAP_BYTES, 1);
      hold_requests = hold_requests + 1;
      for (int i = 0; i < 48; i++) send_pixel(random_pixel(), i == 47);
      wait_drained();
      for (int i = 0; i < 24; i++) send_pixel(random_pixel(), i == 23);
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.rect_x        = '0;
      req_ch.rect_y        = '0;
      req_ch.rect_width    = '0;
      req_ch.rect_height   = '0;
      req_ch.row_stride    = '0;
      req_ch.pixel_format  = FMT_RGB565;
      req_ch.source_column = '0;
      req_ch.source_row    = '0;
      req_ch.pixel_value   = '0;
      rsp_ch.ready         = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_FRAME_WIDTH;
      csr_data             = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_not_ready();
      test_status_order();
      test_conversion_and_clip();
      test_frame_limits();
      test_random_traffic(0);
      test_random_traffic(1);
      test_random_traffic(2);
      test_backpressure();
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_writes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
